@@ rtl/tts_pkg.sv @@
// Package: shared constants, types and saturation and magnitude helpers for the tridiagonal solver.
package tts_pkg;

  localparam int MAX_ROWS_DEF  = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int ROWNUM_W      = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV0_C,
    ST_DIV0_D,
    ST_MUL_MC,
    ST_MUL_MD,
    ST_DIV_C,
    ST_DIV_D,
    ST_BACK_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DATA_W-1:0] quo;
  } div_rsp_t;

  // saturate a 34-bit signed value to 32 bits
  function automatic logic [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
    logic signed [DATA_W+1:0] maxv;
    logic signed [DATA_W+1:0] minv;
    maxv = (DATA_W+2)'(64'sh7FFFFFFF);
    minv = -(DATA_W+2)'(64'sh80000000);
    if (v > maxv) return 32'h7FFFFFFF;
    if (v < minv) return 32'h80000000;
    return v[DATA_W-1:0];
  endfunction

  // signed value from magnitude, saturated
  function automatic logic [DATA_W-1:0] from_mag(input logic [63:0] mag, input logic neg);
    if (neg) begin
      if (mag >= 64'h80000000) return 32'h80000000;
      return DATA_W'(-mag);
    end
    if (mag > 64'h7FFFFFFF) return 32'h7FFFFFFF;
    return mag[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? DATA_W'(-v) : v;
  endfunction

endpackage

@@ rtl/tts_div.sv @@
// Restoring divider: rounded fixed-point quotient, one bit per cycle.
module tts_div #(
  parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tts_pkg::div_req_t   req,
  output tts_pkg::div_rsp_t   rsp
);
  localparam int NW = tts_pkg::DATA_W + FRAC_BITS + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]  num_r, num_nxt;
  logic [NW-1:0]  quo_r, quo_nxt;
  logic [NW:0]    rem_r, rem_nxt;
  logic [tts_pkg::DATA_W:0] den_r, den_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           neg_r, neg_nxt;
  logic           done_r, done_nxt;
  logic [NW:0]    trial;

  // quotient of (2*|n|*2^F + |d|) / (2*|d|)
  always_comb begin
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (req.start) begin
      num_nxt  = (NW'(tts_pkg::mag32(req.num)) << (FRAC_BITS + 1))
                 + NW'(tts_pkg::mag32(req.den));
      den_nxt  = {tts_pkg::mag32(req.den), 1'b0};
      neg_nxt  = req.num[tts_pkg::DATA_W-1] ^ req.den[tts_pkg::DATA_W-1];
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial   = {rem_r[NW-1:0], num_r[NW-1]};
      num_nxt = {num_r[NW-2:0], 1'b0};
      if (trial >= (NW+1)'(den_r)) begin
        rem_nxt = trial - (NW+1)'(den_r);
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = tts_pkg::from_mag(64'(quo_r), neg_r);
endmodule

@@ rtl/tridiagonal_thomas_solver.sv @@
// Top level: tridiagonal system solver, Thomas algorithm, signed fixed point.
// Usage:
//   Rows enter one per item on in_* with start; an item is taken when start is
//   high and busy is low. A row with in_last_row low is stored; busy stays low.
//   The row with in_last_row high starts the solve; busy stays high until every
//   unknown has gone out.
//   Results appear on out_* for one cycle each, marked by out_valid, in row
//   order, out_last_solution on the final one. The receiver cannot stall.
//   Divisions go through the shared bit-serial divider, which sets the pace of a
//   solve; products use one 32x32 multiplier, at most one per cycle.
//   A zero pivot ends the forward sweep and the right-hand sides are returned
//   with out_zero_pivot high.
//   Reset (rst_n low, synchronous) empties the row count and idles the sequencer.
module tridiagonal_thomas_solver #(
  parameter int MAX_ROWS  = tts_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_sub_diag,
  input  logic signed [31:0] in_main_diag,
  input  logic signed [31:0] in_super_diag,
  input  logic signed [31:0] in_rhs_value,
  input  logic        in_last_row,
  output logic        out_valid,
  output logic signed [31:0] out_solution_value,
  output logic [1:0]  out_row_number,
  output logic        out_last_solution,
  output logic        out_zero_pivot
);
  localparam int DW = tts_pkg::DATA_W;
  localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);

  logic [DW-1:0] sub_mem   [MAX_ROWS];
  logic [DW-1:0] diag_mem  [MAX_ROWS];
  logic [DW-1:0] super_mem [MAX_ROWS];
  logic [DW-1:0] rhs_mem   [MAX_ROWS];
  logic [DW-1:0] ratio_mem [MAX_ROWS];
  logic [DW-1:0] mrhs_mem  [MAX_ROWS];

  tts_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] rows_r, rows_nxt;
  logic [IW-1:0] last_r, last_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          flag_r, flag_nxt;
  logic [DW-1:0] m_r, m_nxt;
  logic [DW-1:0] x_r, x_nxt;
  logic [DW-1:0] sol_mem [MAX_ROWS];
  logic          valid_r, valid_nxt;
  logic [DW-1:0] oval_r, oval_nxt;
  logic [1:0]    orow_r, orow_nxt;
  logic          olast_r, olast_nxt;

  tts_pkg::div_req_t dreq;
  tts_pkg::div_rsp_t drsp;

  logic [IW-1:0] slot;
  logic          accept;
  logic [IW-1:0] prev;
  logic [DW-1:0] mul_a, mul_b;
  logic signed [2*DW-1:0] prod;
  logic [2*DW-1:0] pmag;
  logic [DW-1:0] mul_q;
  logic [DW-1:0] diff_a;
  logic [DW-1:0] diff;
  logic          wr_ratio, wr_mrhs, wr_sol;
  logic [DW-1:0] wr_val;

  tts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk), .rst_n(rst_n), .req(dreq), .rsp(drsp)
  );

  assign accept = start && !busy;
  assign slot = (rows_r < CW'(MAX_ROWS)) ? rows_r[IW-1:0] : IW'(MAX_ROWS - 1);
  assign prev = idx_r - 1'b1;

  // shared multiplier and subtractor
  assign prod  = $signed(mul_a) * $signed(mul_b);
  assign pmag  = prod[2*DW-1] ? -prod : prod;
  assign mul_q = tts_pkg::from_mag((pmag + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS,
                                   prod[2*DW-1]);
  assign diff  = tts_pkg::sat34((DW+2)'($signed(diff_a)) - (DW+2)'($signed(mul_q)));

  always_comb begin
    state_nxt = state_r;
    rows_nxt  = rows_r;
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    flag_nxt  = flag_r;
    m_nxt     = m_r;
    x_nxt     = x_r;
    valid_nxt = 1'b0;
    oval_nxt  = oval_r;
    orow_nxt  = orow_r;
    olast_nxt = 1'b0;
    dreq      = '0;
    mul_a     = '0;
    mul_b     = '0;
    diff_a    = '0;
    wr_ratio  = 1'b0;
    wr_mrhs   = 1'b0;
    wr_sol    = 1'b0;
    wr_val    = drsp.quo;
    busy      = (state_r != tts_pkg::ST_IDLE);
    unique case (state_r)
      tts_pkg::ST_IDLE: begin
        if (accept) begin
          if (!in_last_row) begin
            rows_nxt = CW'(slot) + 1'b1;
          end else begin
            rows_nxt = '0;
            last_nxt = slot;
            idx_nxt  = '0;
            flag_nxt = 1'b0;
            state_nxt = tts_pkg::ST_DIV0_C;
          end
        end
      end
      tts_pkg::ST_DIV0_C: begin
        if (diag_mem[0] == '0) begin
          flag_nxt  = 1'b1;
          idx_nxt   = '0;
          state_nxt = tts_pkg::ST_EMIT;
        end else begin
          m_nxt     = diag_mem[0];
          dreq.start = 1'b1;
          dreq.num  = super_mem[0];
          dreq.den  = diag_mem[0];
          state_nxt = tts_pkg::ST_DIV_C;
        end
      end
      tts_pkg::ST_DIV0_D: begin
        state_nxt = tts_pkg::ST_DIV0_D;
      end
      tts_pkg::ST_MUL_MC: begin
        mul_a  = sub_mem[idx_r];
        mul_b  = ratio_mem[prev];
        diff_a = diag_mem[idx_r];
        m_nxt  = diff;
        if (diff == '0) begin
          flag_nxt  = 1'b1;
          idx_nxt   = '0;
          state_nxt = tts_pkg::ST_EMIT;
        end else begin
          state_nxt = tts_pkg::ST_MUL_MD;
        end
      end
      tts_pkg::ST_MUL_MD: begin
        mul_a  = sub_mem[idx_r];
        mul_b  = mrhs_mem[prev];
        diff_a = rhs_mem[idx_r];
        x_nxt  = diff;
        dreq.start = 1'b1;
        dreq.num   = super_mem[idx_r];
        dreq.den   = m_r;
        state_nxt  = tts_pkg::ST_DIV_C;
      end
      tts_pkg::ST_DIV_C: begin
        if (drsp.done) begin
          wr_ratio   = 1'b1;
          dreq.start = 1'b1;
          dreq.num   = (idx_r == '0) ? rhs_mem[0] : x_r;
          dreq.den   = m_r;
          state_nxt  = tts_pkg::ST_DIV_D;
        end
      end
      tts_pkg::ST_DIV_D: begin
        if (drsp.done) begin
          wr_mrhs = 1'b1;
          if (idx_r == last_r) begin
            x_nxt     = drsp.quo;
            wr_sol    = 1'b1;
            state_nxt = (idx_r == '0) ? tts_pkg::ST_EMIT : tts_pkg::ST_BACK_MUL;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = tts_pkg::ST_MUL_MC;
          end
        end
      end
      tts_pkg::ST_BACK_MUL: begin
        mul_a  = ratio_mem[prev];
        mul_b  = x_r;
        diff_a = mrhs_mem[prev];
        x_nxt  = diff;
        wr_val = diff;
        wr_sol = 1'b1;
        idx_nxt = prev;
        if (prev == '0) state_nxt = tts_pkg::ST_EMIT;
      end
      tts_pkg::ST_EMIT: begin
        valid_nxt = 1'b1;
        oval_nxt  = flag_r ? rhs_mem[idx_r] : sol_mem[idx_r];
        orow_nxt  = 2'(idx_r);
        olast_nxt = (idx_r == last_r);
        if (idx_r == last_r) state_nxt = tts_pkg::ST_IDLE;
        else idx_nxt = idx_r + 1'b1;
      end
      default: state_nxt = tts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sub_mem[slot]   <= in_sub_diag;
      diag_mem[slot]  <= in_main_diag;
      super_mem[slot] <= in_super_diag;
      rhs_mem[slot]   <= in_rhs_value;
    end
    if (wr_ratio) ratio_mem[idx_r] <= drsp.quo;
    if (wr_mrhs)  mrhs_mem[idx_r]  <= drsp.quo;
    if (wr_sol)   sol_mem[(state_r == tts_pkg::ST_BACK_MUL) ? prev : idx_r] <= wr_val;
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    idx_r  <= idx_nxt;
    flag_r <= flag_nxt;
    m_r    <= m_nxt;
    x_r    <= x_nxt;
    oval_r <= oval_nxt;
    orow_r <= orow_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      state_r <= tts_pkg::ST_IDLE;
      rows_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rows_r  <= rows_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_solution_value = oval_r;
  assign out_row_number     = orow_r;
  assign out_last_solution  = olast_r & valid_r;
  assign out_zero_pivot     = flag_r;
endmodule
